// File: hw/rtl/tspd_pkg.sv
// Package for the transport-stream PID channel demux.
// Holds sizes, command and register codes, and the item, result and table-write types.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package tspd_pkg;

  // The masks on the result channel carry one bit per channel, so the channel
  // count is tied to their width.
  localparam int unsigned CHANNELS         = 8;
  localparam int unsigned PIDS_PER_CHANNEL = 8;
  localparam int unsigned PID_W            = 13;
  localparam int unsigned CNT_W            = 16;
  localparam int unsigned FILL_W           = 6;
  localparam int unsigned PPD_W            = 7;
  localparam int unsigned TICK_W           = 32;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;

  localparam logic [PID_W-1:0] PID_PAT = 13'd0;
  localparam logic [PID_W-1:0] PID_EIT = 13'd18;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;
  localparam logic [PPD_W-1:0] PPD_MAX = 7'd64;

  localparam logic [3:0]       NUM_CHANNELS_RST  = 4'd8;
  localparam logic [CNT_W-1:0] ACTIVE_THRESH_RST = 16'd100;
  localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RST  = 16'd60;
  localparam logic [CNT_W-1:0] MISS_LIMIT_RST    = 16'd1000;
  localparam logic [PPD_W-1:0] PPD_RST           = 7'd7;

  typedef enum logic [1:0] {
    CMD_PACKET   = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_TABLE_WR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_CHANNELS  = 3'd0,
    REG_ACTIVE_THRESH = 3'd1,
    REG_IDLE_TIMEOUT  = 3'd2,
    REG_MISS_LIMIT    = 3'd3,
    REG_PKTS_PER_DGRAM = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [7:0]       hdr_byte1;
    logic [7:0]       hdr_byte2;
    logic [2:0]       entry_channel;
    logic [2:0]       entry_slot;
    logic [PID_W-1:0] entry_pid;
    logic             entry_valid;
  } item_t;

  typedef struct packed {
    logic [CHANNELS-1:0] matched_mask;
    logic [CHANNELS-1:0] flush_mask;
    logic [CHANNELS-1:0] active_mask;
    logic                miss_alarm;
    logic                idle_stop;
  } result_t;

  // Write request from the datapath into the PID table.
  typedef struct packed {
    logic             en;
    logic [2:0]       channel;
    logic [2:0]       slot;
    logic [PID_W-1:0] pid;
    logic             valid;
  } tbl_wr_t;

endpackage

`default_nettype wire

// File: hw/rtl/tspd_if.sv
// Valid/ready channel interfaces of the PID channel demux: input items,
// results and configuration writes. Depends on tspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tspd_item_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  cmd;
  logic [7:0]                  hdr_byte1;
  logic [7:0]                  hdr_byte2;
  logic [2:0]                  entry_channel;
  logic [2:0]                  entry_slot;
  logic [tspd_pkg::PID_W-1:0]  entry_pid;
  logic                        entry_valid;

  modport source (output valid, cmd, hdr_byte1, hdr_byte2, entry_channel, entry_slot,
                  entry_pid, entry_valid, input ready);
  modport sink (input valid, cmd, hdr_byte1, hdr_byte2, entry_channel, entry_slot,
                entry_pid, entry_valid, output ready);
endinterface

interface tspd_result_if;
  logic                           valid;
  logic                           ready;
  logic [tspd_pkg::CHANNELS-1:0]  matched_mask;
  logic [tspd_pkg::CHANNELS-1:0]  flush_mask;
  logic [tspd_pkg::CHANNELS-1:0]  active_mask;
  logic                           miss_alarm;
  logic                           idle_stop;

  modport source (output valid, matched_mask, flush_mask, active_mask, miss_alarm,
                  idle_stop, input ready);
  modport sink (input valid, matched_mask, flush_mask, active_mask, miss_alarm,
                idle_stop, output ready);
endinterface

interface tspd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tspd_pkg::CFG_IDX_W-1:0]    index;
  logic [tspd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tspd_pid_match.sv
// PID table of the demux: one entry per channel slot, each with its own
// comparator, giving a per-channel hit mask for one PID. Depends on tspd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tspd_pid_match (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tspd_pkg::tbl_wr_t                 wr_i,
  input  wire logic [tspd_pkg::PID_W-1:0]        pid_i,
  output logic      [tspd_pkg::CHANNELS-1:0]     hit_o
);

  logic [tspd_pkg::CHANNELS-1:0][tspd_pkg::PIDS_PER_CHANNEL-1:0] valid_q;
  logic [tspd_pkg::CHANNELS-1:0][tspd_pkg::PIDS_PER_CHANNEL-1:0] slot_hit;
  logic [tspd_pkg::PID_W-1:0] pid_q [tspd_pkg::CHANNELS][tspd_pkg::PIDS_PER_CHANNEL];

  for (genvar c = 0; c < tspd_pkg::CHANNELS; c++) begin : g_chan
    for (genvar s = 0; s < tspd_pkg::PIDS_PER_CHANNEL; s++) begin : g_slot
      logic wr_sel;
      assign wr_sel = wr_i.en && (32'(wr_i.channel) == c) && (32'(wr_i.slot) == s);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[c][s] <= 1'b0;
        end else if (wr_sel) begin
          valid_q[c][s] <= wr_i.valid;
        end
      end

      // A cleared entry never matches, so its PID needs no reset.
      always_ff @(posedge clk_i) begin
        if (wr_sel) begin
          pid_q[c][s] <= wr_i.valid ? wr_i.pid : '0;
        end
      end

      assign slot_hit[c][s] = valid_q[c][s] && (pid_q[c][s] == pid_i);
    end
    assign hit_o[c] = |slot_hit[c];
  end

endmodule

`default_nettype wire

// File: hw/rtl/ts_pid_channel_demux.sv
// Transport-stream PID channel demux, top level.
// Depends on tspd_pkg, the channel interfaces in tspd_if.sv and tspd_pid_match.
//
// Use: items arrive on item_i (valid/ready). A packet-header item is routed by
// its PID to every channel in use whose table holds it; PIDs 0 and 18 reach all
// channels in use. A tick item judges channels active against the threshold and
// tracks how long no channel has been active. A table-write item sets or clears
// one PID slot. Every item gives exactly one transfer on result_o with the
// matched, flush and active masks and the miss alarm and idle stop flags.
// Configuration registers are written on cfg_i, which is always ready; the user
// must write them only while no item is in flight, which the block does not enforce.
// Each item passes an input register, the table compare and counter update,
// and the result register. Throughput: one item per cycle while result_o.ready
// is high or the result register is empty.
// Reset clears the PID table to all invalid, zeroes the counters, marks every
// channel active and loads the register defaults; the block is ready at once.
// When the receiver stalls, the result register holds and one more item waits
// in the input register; after that item_i.ready goes low.
`timescale 1ns / 1ps
`default_nettype none

module ts_pid_channel_demux (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tspd_item_if.sink      item_i,
  tspd_result_if.source  result_o,
  tspd_cfg_if.sink       cfg_i
);

  localparam int unsigned CH = tspd_pkg::CHANNELS;

  // Input stage.
  logic            in_valid_q;
  tspd_pkg::item_t in_q;
  logic            adv;

  // Configuration registers.
  logic [3:0]                      num_channels_q;
  logic [tspd_pkg::CNT_W-1:0]      active_thresh_q;
  logic [tspd_pkg::CNT_W-1:0]      idle_timeout_q;
  logic [tspd_pkg::CNT_W-1:0]      miss_limit_q;
  logic [tspd_pkg::PPD_W-1:0]      ppd_q;

  // Block state.
  logic [CH-1:0][tspd_pkg::CNT_W-1:0]  pkt_cnt_q, pkt_cnt_d;
  logic [CH-1:0][tspd_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [CH-1:0]                       active_q, active_d;
  logic [tspd_pkg::TICK_W-1:0]         tick_q, tick_d;
  logic                                idle_armed_q, idle_armed_d;
  logic [tspd_pkg::TICK_W-1:0]         idle_start_q, idle_start_d;
  logic [tspd_pkg::CNT_W-1:0]          miss_cnt_q, miss_cnt_d;
  logic                                miss_alarm_q, miss_alarm_d;
  logic                                idle_stop_q, idle_stop_d;

  // Output stage.
  logic              out_valid_q;
  tspd_pkg::result_t res_q, res_d;

  // Datapath signals.
  logic [tspd_pkg::PID_W-1:0] pid;
  logic [CH-1:0]              hit;
  logic [CH-1:0]              used;
  tspd_pkg::tbl_wr_t          tbl_wr;

  assign adv           = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready  = !in_valid_q || adv;
  assign cfg_i.ready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q.cmd           <= item_i.cmd;
      in_q.hdr_byte1     <= item_i.hdr_byte1;
      in_q.hdr_byte2     <= item_i.hdr_byte2;
      in_q.entry_channel <= item_i.entry_channel;
      in_q.entry_slot    <= item_i.entry_slot;
      in_q.entry_pid     <= item_i.entry_pid;
      in_q.entry_valid   <= item_i.entry_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q  <= tspd_pkg::NUM_CHANNELS_RST;
      active_thresh_q <= tspd_pkg::ACTIVE_THRESH_RST;
      idle_timeout_q  <= tspd_pkg::IDLE_TIMEOUT_RST;
      miss_limit_q    <= tspd_pkg::MISS_LIMIT_RST;
      ppd_q           <= tspd_pkg::PPD_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (tspd_pkg::cfg_reg_e'(cfg_i.index))
        tspd_pkg::REG_NUM_CHANNELS:   num_channels_q  <= cfg_i.data[3:0];
        tspd_pkg::REG_ACTIVE_THRESH:  active_thresh_q <= cfg_i.data;
        tspd_pkg::REG_IDLE_TIMEOUT:   idle_timeout_q  <= cfg_i.data;
        tspd_pkg::REG_MISS_LIMIT:     miss_limit_q    <= cfg_i.data;
        tspd_pkg::REG_PKTS_PER_DGRAM: ppd_q           <= cfg_i.data[tspd_pkg::PPD_W-1:0];
        default: ;
      endcase
    end
  end

  assign pid = {in_q.hdr_byte1[4:0], in_q.hdr_byte2};

  assign tbl_wr.en      = adv && (tspd_pkg::cmd_e'(in_q.cmd) == tspd_pkg::CMD_TABLE_WR);
  assign tbl_wr.channel = in_q.entry_channel;
  assign tbl_wr.slot    = in_q.entry_slot;
  assign tbl_wr.pid     = in_q.entry_pid;
  assign tbl_wr.valid   = in_q.entry_valid;

  tspd_pid_match u_match (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .pid_i  (pid),
    .hit_o  (hit)
  );

  // A channel is in use below num_channels; values above the channel count
  // therefore enable every channel.
  for (genvar c = 0; c < CH; c++) begin : g_used
    assign used[c] = 32'(num_channels_q) > c;
  end

  always_comb begin
    logic                         common;
    logic [tspd_pkg::PPD_W-1:0]   ppd_eff;
    logic [tspd_pkg::PPD_W-1:0]   fill_inc;
    logic [CH-1:0]                matched;
    logic [CH-1:0]                flushed;
    logic [tspd_pkg::TICK_W-1:0]  idle_span;

    pkt_cnt_d    = pkt_cnt_q;
    fill_d       = fill_q;
    active_d     = active_q;
    tick_d       = tick_q;
    idle_armed_d = idle_armed_q;
    idle_start_d = idle_start_q;
    miss_cnt_d   = miss_cnt_q;
    miss_alarm_d = miss_alarm_q;
    idle_stop_d  = idle_stop_q;
    matched      = '0;
    flushed      = '0;
    idle_span    = '0;
    fill_inc     = '0;

    common = (pid == tspd_pkg::PID_PAT) || (pid == tspd_pkg::PID_EIT);
    if (ppd_q == '0) begin
      ppd_eff = tspd_pkg::PPD_W'(1);
    end else if (ppd_q > tspd_pkg::PPD_MAX) begin
      ppd_eff = tspd_pkg::PPD_MAX;
    end else begin
      ppd_eff = ppd_q;
    end

    unique case (tspd_pkg::cmd_e'(in_q.cmd))
      tspd_pkg::CMD_PACKET: begin
        for (int c = 0; c < CH; c++) begin
          if (used[c] && (common || hit[c])) begin
            matched[c] = 1'b1;
            if (!common && (pkt_cnt_q[c] != tspd_pkg::CNT_MAX)) begin
              pkt_cnt_d[c] = pkt_cnt_q[c] + 1'b1;
            end
            fill_inc = {1'b0, fill_q[c]} + 1'b1;
            if (fill_inc >= ppd_eff) begin
              flushed[c] = 1'b1;
              fill_d[c]  = '0;
            end else begin
              fill_d[c]  = fill_inc[tspd_pkg::FILL_W-1:0];
            end
          end
        end
        if (matched != '0) begin
          miss_cnt_d   = '0;
          miss_alarm_d = 1'b0;
        end else begin
          if (miss_cnt_q != tspd_pkg::CNT_MAX) begin
            miss_cnt_d = miss_cnt_q + 1'b1;
          end
          if (miss_cnt_d > miss_limit_q) begin
            miss_alarm_d = 1'b1;
          end
        end
      end
      tspd_pkg::CMD_TICK: begin
        tick_d = tick_q + 1'b1;
        for (int c = 0; c < CH; c++) begin
          if (used[c]) begin
            active_d[c] = pkt_cnt_q[c] >= active_thresh_q;
          end
        end
        if ((active_d & used) != '0) begin
          idle_armed_d = 1'b0;
          idle_start_d = '0;
        end else if (!idle_armed_q) begin
          idle_armed_d = 1'b1;
          idle_start_d = tick_d;
        end
        idle_span = tick_d - idle_start_d;
        if (idle_armed_d && (idle_span > {16'b0, idle_timeout_q})) begin
          idle_stop_d = 1'b1;
        end
        pkt_cnt_d = '0;
      end
      default: ;
    endcase

    res_d.matched_mask = matched;
    res_d.flush_mask   = flushed;
    res_d.active_mask  = active_d & used;
    res_d.miss_alarm   = miss_alarm_d;
    res_d.idle_stop    = idle_stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_cnt_q    <= '0;
      fill_q       <= '0;
      active_q     <= '1;
      tick_q       <= '0;
      idle_armed_q <= 1'b0;
      idle_start_q <= '0;
      miss_cnt_q   <= '0;
      miss_alarm_q <= 1'b0;
      idle_stop_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (adv) begin
        pkt_cnt_q    <= pkt_cnt_d;
        fill_q       <= fill_d;
        active_q     <= active_d;
        tick_q       <= tick_d;
        idle_armed_q <= idle_armed_d;
        idle_start_q <= idle_start_d;
        miss_cnt_q   <= miss_cnt_d;
        miss_alarm_q <= miss_alarm_d;
        idle_stop_q  <= idle_stop_d;
        out_valid_q  <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.matched_mask = res_q.matched_mask;
  assign result_o.flush_mask   = res_q.flush_mask;
  assign result_o.active_mask  = res_q.active_mask;
  assign result_o.miss_alarm   = res_q.miss_alarm;
  assign result_o.idle_stop    = res_q.idle_stop;

  // A channel can only flush on a packet that reached it.
  a_flush_in_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.flush_mask & ~res_q.matched_mask) == '0))
    else $error("flush reported for a channel that did not match");

  // Nothing is routed to a channel that is not in use.
  a_matched_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((res_q.matched_mask & ~used) == '0))
    else $error("packet routed to a channel not in use");

  // The stop flag is sticky until reset.
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_stop_q |=> idle_stop_q)
    else $error("idle stop dropped without reset");

  // The alarm is only raised after at least one unrouted packet.
  a_alarm_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_alarm_q |-> (miss_cnt_q != '0))
    else $error("miss alarm set with zero miss count");

  // A disarmed idle timer keeps its start mark cleared.
  a_idle_disarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle_armed_q |-> (idle_start_q == '0))
    else $error("idle start mark left over while disarmed");

endmodule

`default_nettype wire
